@@ sv/uer_pkg.sv @@
// Shared types, codes and constants of the ultrasonic echo ranging block.
package uer_pkg;

   localparam int TIME_WIDTH_DEF  = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int TRIG_WIDTH      = 8;
   localparam int TIMEOUT_WIDTH   = 16;
   localparam int RAW_WIDTH       = 11;
   localparam int DIGIT_WIDTH     = 4;
   localparam int REM_WIDTH       = 6;
   localparam int TICKS_PER_CM    = 58;

   localparam logic [RAW_WIDTH-1:0]     RAW_MAX           = '1;
   localparam logic [TRIG_WIDTH-1:0]    TRIGGER_TICKS_RST = 8'd12;
   localparam logic [TIMEOUT_WIDTH-1:0] RISE_TIMEOUT_RST  = 16'd30000;
   localparam logic [TIMEOUT_WIDTH-1:0] ECHO_TIMEOUT_RST  = 16'd30000;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRIGGER_TICKS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RISE_TIMEOUT  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ECHO_TIMEOUT  = 2'd2;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TRIG,
      PH_RISE,
      PH_HIGH
   } phase_type;

   typedef enum logic [2:0] {
      ST_NONE,
      ST_OK,
      ST_RISE_TIMEOUT,
      ST_ECHO_TIMEOUT,
      ST_ZERO
   } status_type;

endpackage

@@ sv/ultrasonic_echo_ranging.sv @@
// Ultrasonic echo ranging controller: trigger, echo timing, smoothing and decimal digits.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+--------------------------------------
//   req     | in        | req_valid / req_ready   | start_req, echo (one microsecond tick)
//   rsp     | out       | rsp_valid / rsp_ready   | trigger, busy_res, status, raw_cm,
//           |           |                         | smoothed_cm, three decimal digits
//   csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// One word per cycle sustained while rsp is not stalled; each accepted req word
// passes both stages before it appears on rsp: the phase, counter and smoothing
// update in the first stage, the decimal split of the smoothed value in the second.
// Synchronous reset restores the register defaults and an idle, zeroed state.
// A stalled rsp holds both stages and then req; csr_ready is always high.
module ultrasonic_echo_ranging #(
   parameter int TIME_WIDTH = uer_pkg::TIME_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_start_req,
   input  logic                                 req_echo,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_trigger,
   output logic                                 rsp_busy_res,
   output uer_pkg::status_type                  rsp_status,
   output logic [uer_pkg::RAW_WIDTH-1:0]        rsp_raw_cm,
   output logic [uer_pkg::RAW_WIDTH-1:0]        rsp_smoothed_cm,
   output logic [uer_pkg::DIGIT_WIDTH-1:0]      rsp_hundreds_digit,
   output logic [uer_pkg::DIGIT_WIDTH-1:0]      rsp_tens_digit,
   output logic [uer_pkg::DIGIT_WIDTH-1:0]      rsp_ones_digit,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [uer_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [uer_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import uer_pkg::*;

   localparam int CW = (TIME_WIDTH > TIMEOUT_WIDTH) ? TIME_WIDTH : TIMEOUT_WIDTH;
   localparam int QW = TIME_WIDTH - 5;
   localparam int RW = (QW > RAW_WIDTH) ? QW : RAW_WIDTH;
   localparam int AW = TIME_WIDTH + 1;
   localparam logic [TIME_WIDTH-1:0] CNT_MAX = '1;

   // configuration
   logic [TRIG_WIDTH-1:0]    trigger_ticks_ff;
   logic [TIMEOUT_WIDTH-1:0] rise_timeout_ff;
   logic [TIMEOUT_WIDTH-1:0] echo_timeout_ff;

   // measurement state
   phase_type             phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] phase_ticks_ff, phase_ticks_in;
   logic [TIME_WIDTH-1:0] echo_ticks_ff, echo_ticks_in;
   logic [QW-1:0]         echo_quot_ff, echo_quot_in;
   logic [REM_WIDTH-1:0]  echo_rem_ff, echo_rem_in;
   logic [RAW_WIDTH-1:0]  last_raw_ff, last_raw_in;
   logic [RAW_WIDTH-1:0]  smoothed_ff, smoothed_in;

   // first stage
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_trigger_ff;
   logic                  s1_busy_ff;
   status_type            s1_status_ff;
   logic [RAW_WIDTH-1:0]  s1_raw_ff;
   logic [RAW_WIDTH-1:0]  s1_smoothed_ff;

   // result stage
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_trigger_ff;
   logic                  rsp_busy_ff;
   status_type            rsp_status_ff;
   logic [RAW_WIDTH-1:0]  rsp_raw_ff;
   logic [RAW_WIDTH-1:0]  rsp_smoothed_ff;
   logic [DIGIT_WIDTH-1:0] rsp_hundreds_ff, rsp_hundreds_in;
   logic [DIGIT_WIDTH-1:0] rsp_tens_ff, rsp_tens_in;
   logic [DIGIT_WIDTH-1:0] rsp_ones_ff, rsp_ones_in;

   logic                  req_take;
   logic                  s1_move;
   logic                  trig_out;
   status_type            status_out;
   logic [TIME_WIDTH-1:0] phase_bump;
   logic [TIME_WIDTH-1:0] echo_bump;
   logic [QW-1:0]         quot_bump;
   logic [REM_WIDTH-1:0]  rem_bump;
   logic                  trig_hit;
   logic                  rise_hit;
   logic                  echo_hit;
   logic [RW-1:0]         quot_ext;
   logic [RAW_WIDTH-1:0]  raw_sat;
   logic [14:0]           smooth_sum;
   logic [31:0]           smooth_prod;
   logic [RAW_WIDTH-1:0]  smooth_new;
   logic [26:0]           div10_prod;
   logic [23:0]           div100_prod;
   logic [7:0]            quot10;
   logic [4:0]            quot100;
   logic [RAW_WIDTH-1:0]  ones_full;
   logic [7:0]            tens_full;

   // handshake
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // saturating counters and the running quotient of echo ticks by 58
   assign phase_bump = (phase_ticks_ff == CNT_MAX) ? CNT_MAX : phase_ticks_ff + 1'b1;
   assign echo_bump  = (echo_ticks_ff == CNT_MAX) ? CNT_MAX : echo_ticks_ff + 1'b1;

   always_comb begin
      quot_bump = echo_quot_ff;
      rem_bump  = echo_rem_ff;
      if (echo_ticks_ff != CNT_MAX) begin
         if (echo_rem_ff == REM_WIDTH'(TICKS_PER_CM - 1)) begin
            rem_bump  = '0;
            quot_bump = echo_quot_ff + 1'b1;
         end else begin
            rem_bump  = echo_rem_ff + 1'b1;
         end
      end
   end

   assign trig_hit = (CW'(phase_bump) >= CW'(trigger_ticks_ff)) || (phase_bump == CNT_MAX);
   assign rise_hit = (CW'(phase_bump) >= CW'(rise_timeout_ff)) || (phase_bump == CNT_MAX);
   assign echo_hit = (CW'(echo_bump) >= CW'(echo_timeout_ff)) || (echo_bump == CNT_MAX);

   assign quot_ext = RW'(echo_quot_ff);
   assign raw_sat  = (quot_ext > RW'(RAW_MAX)) ? RAW_MAX : quot_ext[RAW_WIDTH-1:0];

   // (7*old + 3*new)/10, the divide by ten as a reciprocal multiply
   assign smooth_sum  = 15'(smoothed_ff) * 15'd7 + 15'(raw_sat) * 15'd3;
   assign smooth_prod = 32'(smooth_sum) * 32'd52429;
   assign smooth_new  = smooth_prod[29:19];

   always_comb begin
      phase_in       = phase_ff;
      phase_ticks_in = phase_ticks_ff;
      echo_ticks_in  = echo_ticks_ff;
      echo_quot_in   = echo_quot_ff;
      echo_rem_in    = echo_rem_ff;
      last_raw_in    = last_raw_ff;
      smoothed_in    = smoothed_ff;
      trig_out       = 1'b0;
      status_out     = ST_NONE;
      if (req_take) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (req_start_req) begin
                  trig_out      = 1'b1;
                  echo_ticks_in = '0;
                  echo_quot_in  = '0;
                  echo_rem_in   = '0;
                  if (trigger_ticks_ff <= TRIG_WIDTH'(1)) begin
                     phase_in       = PH_RISE;
                     phase_ticks_in = '0;
                  end else begin
                     phase_in       = PH_TRIG;
                     phase_ticks_in = TIME_WIDTH'(1);
                  end
               end
            end
            PH_TRIG: begin
               trig_out = 1'b1;
               if (trig_hit) begin
                  phase_in       = PH_RISE;
                  phase_ticks_in = '0;
               end else begin
                  phase_ticks_in = phase_bump;
               end
            end
            PH_RISE: begin
               if (req_echo) begin
                  echo_ticks_in = TIME_WIDTH'(1);
                  echo_quot_in  = '0;
                  echo_rem_in   = REM_WIDTH'(1);
                  if (echo_timeout_ff <= TIMEOUT_WIDTH'(1)) begin
                     phase_in    = PH_IDLE;
                     last_raw_in = '0;
                     status_out  = ST_ECHO_TIMEOUT;
                  end else begin
                     phase_in    = PH_HIGH;
                  end
               end else begin
                  phase_ticks_in = phase_bump;
                  if (rise_hit) begin
                     phase_in    = PH_IDLE;
                     last_raw_in = '0;
                     status_out  = ST_RISE_TIMEOUT;
                  end
               end
            end
            PH_HIGH: begin
               if (req_echo) begin
                  echo_ticks_in = echo_bump;
                  echo_quot_in  = quot_bump;
                  echo_rem_in   = rem_bump;
                  if (echo_hit) begin
                     phase_in    = PH_IDLE;
                     last_raw_in = '0;
                     status_out  = ST_ECHO_TIMEOUT;
                  end
               end else begin
                  phase_in    = PH_IDLE;
                  last_raw_in = raw_sat;
                  if (raw_sat == '0) begin
                     status_out  = ST_ZERO;
                  end else begin
                     smoothed_in = smooth_new;
                     status_out  = ST_OK;
                  end
               end
            end
         endcase
      end
   end

   // decimal split of the smoothed value
   assign div10_prod  = 27'(s1_smoothed_ff) * 27'd52429;
   assign div100_prod = 24'(s1_smoothed_ff) * 24'd5243;
   assign quot10      = div10_prod[26:19];
   assign quot100     = div100_prod[23:19];
   assign ones_full   = s1_smoothed_ff - RAW_WIDTH'(quot10) * RAW_WIDTH'(10);
   assign tens_full   = quot10 - 8'(quot100) * 8'd10;
   assign rsp_ones_in = ones_full[DIGIT_WIDTH-1:0];
   assign rsp_tens_in = tens_full[DIGIT_WIDTH-1:0];

   always_comb begin
      if (quot100 >= 5'd20) begin
         rsp_hundreds_in = DIGIT_WIDTH'(quot100 - 5'd20);
      end else if (quot100 >= 5'd10) begin
         rsp_hundreds_in = DIGIT_WIDTH'(quot100 - 5'd10);
      end else begin
         rsp_hundreds_in = DIGIT_WIDTH'(quot100);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ticks_ff <= TRIGGER_TICKS_RST;
         rise_timeout_ff  <= RISE_TIMEOUT_RST;
         echo_timeout_ff  <= ECHO_TIMEOUT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TRIGGER_TICKS: trigger_ticks_ff <= csr_data[TRIG_WIDTH-1:0];
            CSR_RISE_TIMEOUT:  rise_timeout_ff  <= csr_data[TIMEOUT_WIDTH-1:0];
            CSR_ECHO_TIMEOUT:  echo_timeout_ff  <= csr_data[TIMEOUT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         phase_ticks_ff <= '0;
         echo_ticks_ff  <= '0;
         echo_quot_ff   <= '0;
         echo_rem_ff    <= '0;
         last_raw_ff    <= '0;
         smoothed_ff    <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         phase_ticks_ff <= phase_ticks_in;
         echo_ticks_ff  <= echo_ticks_in;
         echo_quot_ff   <= echo_quot_in;
         echo_rem_ff    <= echo_rem_in;
         last_raw_ff    <= last_raw_in;
         smoothed_ff    <= smoothed_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_trigger_ff  <= trig_out;
         s1_busy_ff     <= (phase_in != PH_IDLE);
         s1_status_ff   <= status_out;
         s1_raw_ff      <= last_raw_in;
         s1_smoothed_ff <= smoothed_in;
      end
      if (s1_move) begin
         rsp_trigger_ff  <= s1_trigger_ff;
         rsp_busy_ff     <= s1_busy_ff;
         rsp_status_ff   <= s1_status_ff;
         rsp_raw_ff      <= s1_raw_ff;
         rsp_smoothed_ff <= s1_smoothed_ff;
         rsp_hundreds_ff <= rsp_hundreds_in;
         rsp_tens_ff     <= rsp_tens_in;
         rsp_ones_ff     <= rsp_ones_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_trigger        = rsp_trigger_ff;
   assign rsp_busy_res       = rsp_busy_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_raw_cm         = rsp_raw_ff;
   assign rsp_smoothed_cm    = rsp_smoothed_ff;
   assign rsp_hundreds_digit = rsp_hundreds_ff;
   assign rsp_tens_digit     = rsp_tens_ff;
   assign rsp_ones_digit     = rsp_ones_ff;

   a_trigger_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trigger |-> rsp_busy_res)
      else $error("trigger driven outside a measurement");

   a_quot_track: assert property (@(posedge clock) disable iff (reset)
      AW'(echo_quot_ff) * AW'(TICKS_PER_CM) + AW'(echo_rem_ff) == AW'(echo_ticks_ff))
      else $error("echo quotient and remainder out of step with tick count");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !req_take |=> $stable(phase_ff) && $stable(smoothed_ff) && $stable(echo_ticks_ff))
      else $error("measurement state moved without an accepted word");

   a_status_idle: assert property (@(posedge clock) disable iff (reset)
      req_take && status_out != ST_NONE |=> phase_ff == PH_IDLE)
      else $error("measurement ended but phase not idle");

endmodule

@@ bench/ultrasonic_echo_ranging_checker.sv @@
// Checker of the echo ranging block: predicts every result word and compares it.
module ultrasonic_echo_ranging_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_start_req,
   input  logic                                 req_echo,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic                                 rsp_trigger,
   input  logic                                 rsp_busy_res,
   input  uer_pkg::status_type                  rsp_status,
   input  logic [uer_pkg::RAW_WIDTH-1:0]        rsp_raw_cm,
   input  logic [uer_pkg::RAW_WIDTH-1:0]        rsp_smoothed_cm,
   input  logic [uer_pkg::DIGIT_WIDTH-1:0]      rsp_hundreds_digit,
   input  logic [uer_pkg::DIGIT_WIDTH-1:0]      rsp_tens_digit,
   input  logic [uer_pkg::DIGIT_WIDTH-1:0]      rsp_ones_digit,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [uer_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [uer_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output int                                   fail_count,
   output int                                   pending
);
   import uer_pkg::*;

   typedef struct packed {
      logic                   trigger;
      logic                   busy;
      status_type             status;
      logic [RAW_WIDTH-1:0]   raw_cm;
      logic [RAW_WIDTH-1:0]   smoothed_cm;
      logic [DIGIT_WIDTH-1:0] hundreds;
      logic [DIGIT_WIDTH-1:0] tens;
      logic [DIGIT_WIDTH-1:0] ones;
   } reading_type;

   logic [TRIG_WIDTH-1:0]    trig_len;
   logic [TIMEOUT_WIDTH-1:0] rise_limit;
   logic [TIMEOUT_WIDTH-1:0] echo_limit;

   phase_type                phase;
   logic [TIME_WIDTH_DEF-1:0] tick_count;
   logic [TIME_WIDTH_DEF-1:0] high_count;
   logic [RAW_WIDTH-1:0]     raw_dist;
   logic [RAW_WIDTH-1:0]     smooth_dist;

   reading_type expected_readings[$];
   reading_type want;
   int mismatches = 0;
   int waiting = 0;

   assign fail_count = mismatches;
   assign pending    = waiting;

   function automatic logic [TIME_WIDTH_DEF-1:0] count_up(logic [TIME_WIDTH_DEF-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   function automatic logic limit_hit(logic [TIME_WIDTH_DEF-1:0] c, int limit);
      return (int'(c) >= limit) || (c == '1);
   endfunction

   function automatic reading_type range_tick(logic start, logic echo);
      reading_type r;
      int          raw;
      logic        trig;
      status_type  st;
      trig = 1'b0;
      st   = ST_NONE;
      case (phase)
         PH_IDLE: begin
            if (start) begin
               trig       = 1'b1;
               phase      = PH_TRIG;
               tick_count = TIME_WIDTH_DEF'(1);
               high_count = '0;
               if (limit_hit(tick_count, int'(trig_len))) begin
                  phase      = PH_RISE;
                  tick_count = '0;
               end
            end
         end
         PH_TRIG: begin
            trig       = 1'b1;
            tick_count = count_up(tick_count);
            if (limit_hit(tick_count, int'(trig_len))) begin
               phase      = PH_RISE;
               tick_count = '0;
            end
         end
         PH_RISE: begin
            if (echo) begin
               phase      = PH_HIGH;
               high_count = TIME_WIDTH_DEF'(1);
               if (limit_hit(high_count, int'(echo_limit))) begin
                  phase    = PH_IDLE;
                  raw_dist = '0;
                  st       = ST_ECHO_TIMEOUT;
               end
            end else begin
               tick_count = count_up(tick_count);
               if (limit_hit(tick_count, int'(rise_limit))) begin
                  phase    = PH_IDLE;
                  raw_dist = '0;
                  st       = ST_RISE_TIMEOUT;
               end
            end
         end
         default: begin
            if (echo) begin
               high_count = count_up(high_count);
               if (limit_hit(high_count, int'(echo_limit))) begin
                  phase    = PH_IDLE;
                  raw_dist = '0;
                  st       = ST_ECHO_TIMEOUT;
               end
            end else begin
               raw = int'(high_count) / TICKS_PER_CM;
               if (raw > int'(RAW_MAX)) raw = int'(RAW_MAX);
               raw_dist = RAW_WIDTH'(raw);
               phase    = PH_IDLE;
               if (raw == 0) begin
                  st = ST_ZERO;
               end else begin
                  smooth_dist = RAW_WIDTH'((int'(smooth_dist) * 7 + raw * 3) / 10);
                  st          = ST_OK;
               end
            end
         end
      endcase
      r.trigger     = trig;
      r.busy        = (phase != PH_IDLE);
      r.status      = st;
      r.raw_cm      = raw_dist;
      r.smoothed_cm = smooth_dist;
      r.hundreds    = DIGIT_WIDTH'(int'(smooth_dist) / 100 % 10);
      r.tens        = DIGIT_WIDTH'(int'(smooth_dist) / 10 % 10);
      r.ones        = DIGIT_WIDTH'(int'(smooth_dist) % 10);
      return r;
   endfunction

   task automatic check_field(string field, int expected_val, int actual_val);
      if (expected_val != actual_val) begin
         $error("%s: expected %0d, actual %0d", field, expected_val, actual_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         trig_len    = TRIGGER_TICKS_RST;
         rise_limit  = RISE_TIMEOUT_RST;
         echo_limit  = ECHO_TIMEOUT_RST;
         phase       = PH_IDLE;
         tick_count  = '0;
         high_count  = '0;
         raw_dist    = '0;
         smooth_dist = '0;
         expected_readings.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TRIGGER_TICKS: trig_len   = csr_data[TRIG_WIDTH-1:0];
               CSR_RISE_TIMEOUT:  rise_limit = csr_data[TIMEOUT_WIDTH-1:0];
               CSR_ECHO_TIMEOUT:  echo_limit = csr_data[TIMEOUT_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_readings.push_back(range_tick(req_start_req, req_echo));
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               $error("result word with nothing expected");
               mismatches++;
            end else begin
               want = expected_readings.pop_front();
               check_field("trigger", int'(want.trigger), int'(rsp_trigger));
               check_field("busy_res", int'(want.busy), int'(rsp_busy_res));
               check_field("status", int'(want.status), int'(rsp_status));
               check_field("raw_cm", int'(want.raw_cm), int'(rsp_raw_cm));
               check_field("smoothed_cm", int'(want.smoothed_cm), int'(rsp_smoothed_cm));
               check_field("hundreds_digit", int'(want.hundreds), int'(rsp_hundreds_digit));
               check_field("tens_digit", int'(want.tens), int'(rsp_tens_digit));
               check_field("ones_digit", int'(want.ones), int'(rsp_ones_digit));
            end
         end
      end
      waiting <= expected_readings.size();
   end

endmodule

@@ bench/ultrasonic_echo_ranging_tb.sv @@
// Testbench top of the echo ranging block: clock, reset, tick and register stimulus, verdict.
module ultrasonic_echo_ranging_tb;
   import uer_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 80;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid     = 1'b0;
   logic                        req_ready;
   logic                        req_start_req = 1'b0;
   logic                        req_echo      = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready     = 1'b0;
   logic                        rsp_trigger;
   logic                        rsp_busy_res;
   status_type                  rsp_status;
   logic [RAW_WIDTH-1:0]        rsp_raw_cm;
   logic [RAW_WIDTH-1:0]        rsp_smoothed_cm;
   logic [DIGIT_WIDTH-1:0]      rsp_hundreds_digit;
   logic [DIGIT_WIDTH-1:0]      rsp_tens_digit;
   logic [DIGIT_WIDTH-1:0]      rsp_ones_digit;
   logic                        csr_valid     = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index     = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_data      = '0;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int ticks_sent  = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_token  = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int trig_cfg    = int'(TRIGGER_TICKS_RST);
   int rise_cfg    = int'(RISE_TIMEOUT_RST);
   int echo_cfg    = int'(ECHO_TIMEOUT_RST);

   ultrasonic_echo_ranging uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_req      (req_start_req),
      .req_echo           (req_echo),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_trigger        (rsp_trigger),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_status         (rsp_status),
      .rsp_raw_cm         (rsp_raw_cm),
      .rsp_smoothed_cm    (rsp_smoothed_cm),
      .rsp_hundreds_digit (rsp_hundreds_digit),
      .rsp_tens_digit     (rsp_tens_digit),
      .rsp_ones_digit     (rsp_ones_digit),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   ultrasonic_echo_ranging_checker ranging_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_req      (req_start_req),
      .req_echo           (req_echo),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_trigger        (rsp_trigger),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_status         (rsp_status),
      .rsp_raw_cm         (rsp_raw_cm),
      .rsp_smoothed_cm    (rsp_smoothed_cm),
      .rsp_hundreds_digit (rsp_hundreds_digit),
      .rsp_tens_digit     (rsp_tens_digit),
      .rsp_ones_digit     (rsp_ones_digit),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_token) begin
         hold_seen <= hold_token;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   function automatic logic coin();
      return 1'($urandom_range(1));
   endfunction

   task automatic send_tick(input logic start, input logic echo);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_start_req <= start;
      req_echo      <= echo;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [TRIG_WIDTH-1:0] trig,
                            input logic [TIMEOUT_WIDTH-1:0] rise,
                            input logic [TIMEOUT_WIDTH-1:0] echo,
                            input bit spare);
      wait_drained();
      write_reg(CSR_TRIGGER_TICKS, {8'($urandom_range(255)), trig});
      write_reg(CSR_RISE_TIMEOUT, rise);
      write_reg(CSR_ECHO_TIMEOUT, echo);
      if (spare) write_reg(CSR_SPARE, 16'($urandom_range(65535)));
      csr_valid <= 1'b0;
      trig_cfg = int'(trig);
      rise_cfg = int'(rise);
      echo_cfg = int'(echo);
   endtask

   task automatic measure_once();
      int gap;
      int high;
      int pick;
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 6)) send_tick(coin(), coin());
         return;
      end
      send_tick(1'b1, coin());
      repeat ((trig_cfg > 1) ? trig_cfg - 1 : 0) send_tick(coin(), coin());
      if (rise_cfg <= 64 && $urandom_range(99) < 12) begin
         repeat ((rise_cfg > 0) ? rise_cfg : 1) send_tick(coin(), 1'b0);
         return;
      end
      gap = (rise_cfg > 1) ? $urandom_range(0, (rise_cfg - 1 < 8) ? rise_cfg - 1 : 8) : 0;
      repeat (gap) send_tick(coin(), 1'b0);
      pick = $urandom_range(99);
      if (pick < 10 && echo_cfg <= 700)
         high = (echo_cfg > 0) ? echo_cfg : 1;
      else if (pick < 25)
         high = $urandom_range(1, 57);
      else if (pick < 35)
         high = $urandom_range(58, 700);
      else
         high = $urandom_range(58, 140);
      repeat (high) send_tick(coin(), 1'b1);
      send_tick(coin(), 1'b0);
      repeat ($urandom_range(0, 3)) send_tick(1'b0, coin());
   endtask

   task automatic run_random(input int budget);
      int stop;
      stop = ticks_sent + budget;
      while (ticks_sent < stop) measure_once();
   endtask

   initial begin
      tx_idle_pct = 23;
      rx_idle_pct <= 48;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b1);
      for (int i = 0; i < 11; i++) send_tick(1'b1, 1'(i));
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);

      configure(8'd0, 16'd0, 16'd0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);

      configure(8'd255, 16'd65535, 16'd65535, 1'b0);
      run_random(500);
      configure(8'd1, 16'd1, 16'd1, 1'b0);
      run_random(200);

      tx_idle_pct = 48;
      rx_idle_pct <= 23;
      configure(8'd3, 16'd20, 16'd200, 1'b1);
      hold_token <= hold_token + 1;
      run_random(700);

      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      configure(TRIGGER_TICKS_RST, RISE_TIMEOUT_RST, ECHO_TIMEOUT_RST, 1'b0);
      run_random(550);

      wait_drained();
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
